### rtl/baro_comp_pkg.sv
// ----------------------------------------------------------------------------
// Barometric compensation package
// Shared types, constants and helper functions for the compensation block.
// ----------------------------------------------------------------------------
package baro_comp_pkg;

  localparam int RAW_W     = 20;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;
  localparam int QCNT_W    = 3;
  localparam int ADDR_W    = 5;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_TCOEF = 2'd0;
  localparam logic [1:0] REG_PCOA  = 2'd1;
  localparam logic [1:0] REG_PCOB  = 2'd2;
  localparam logic [1:0] REG_P9    = 2'd3;

  localparam logic [63:0] T_OFFSET  = 64'd128000;
  localparam logic [63:0] P_BASE    = 64'd1048576;
  localparam logic [63:0] P_SCALE   = 64'd3125;
  localparam logic [63:0] P_ONE47   = 64'h0000_8000_0000_0000;

  // Calibration words as seen by the back end.
  typedef struct packed {
    logic [47:0] tcoef;
    logic [63:0] pcoa;
    logic [63:0] pcob;
    logic [15:0] p9;
  } bc_coef_t;

  // One queued item between the front and back ends.
  typedef struct packed {
    logic [RAW_W-1:0] raw_p;
    logic [RAW_W-1:0] raw_t;
  } bc_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ISSUE, ST_WAIT, ST_DIV_WAIT, ST_SUM, ST_PACK, ST_DONE
  } bc_state_t;

  // Which multiplication the sequencer is on.
  typedef enum logic [3:0] {
    MS_A_T2, MS_B_B, MS_S_T3, MS_W_W, MS_WW_P6, MS_W_P5, MS_WW_P3,
    MS_W_P2, MS_X_P1, MS_N_K, MS_P9_Q, MS_R_Q, MS_P8_P
  } bc_step_t;

  function automatic logic [63:0] sext16(input logic [15:0] v);
    sext16 = {{48{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sra32(input logic [31:0] x, input int n);
    sra32 = 32'($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] sra64(input logic [63:0] x, input int n);
    sra64 = 64'($signed(x) >>> n);
  endfunction

endpackage

### rtl/baro_comp_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accepts input beats, trims the raw samples to the used resolution and
// holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module baro_comp_front import baro_comp_pkg::*; #(
  parameter int RAW_BITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic        pop,
  output logic        q_valid,
  output bc_item_t    q_head
);

  localparam logic [RAW_W-1:0] KEEP = ~((RAW_W'(1) << (RAW_W - RAW_BITS)) - RAW_W'(1));

  bc_item_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic                push;
  bc_item_t            item;

  assign in_tready = (cnt_r != QCNT_W'(QDEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign q_head    = mem_r[rd_ptr_r];

  // Clear the unused low bits of each sample.
  always_comb begin
    item.raw_t = in_tdata[RAW_W-1:0] & KEEP;
    item.raw_p = in_tdata[2*RAW_W-1:RAW_W] & KEEP;
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

### rtl/baro_comp_mul.sv
// ----------------------------------------------------------------------------
// Wrapping 64-bit multiplier
// Forms the low 64 bits of a product from three 32x32 partial products,
// one per cycle, on a single shared multiplier.
// ----------------------------------------------------------------------------
module baro_comp_mul import baro_comp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] op_a,
  input  logic [63:0] op_b,
  output logic        done,
  output logic [63:0] prod
);

  logic [63:0] a_r, b_r, lo_r, res_r;
  logic [31:0] cr_r, ma, mb;
  logic [63:0] pp;
  logic [1:0]  ph_r;
  logic        busy_r, done_r;

  // Operand select for the current partial product.
  assign ma = (ph_r == 2'd2) ? a_r[63:32] : a_r[31:0];
  assign mb = (ph_r == 2'd1) ? b_r[63:32] : b_r[31:0];
  assign pp = 64'(ma) * 64'(mb);

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= op_a;
      b_r <= op_b;
    end
    if (busy_r) begin
      case (ph_r)
        2'd0:    lo_r  <= pp;
        2'd1:    cr_r  <= pp[31:0];
        2'd2:    cr_r  <= cr_r + pp[31:0];
        default: res_r <= lo_r + {cr_r, 32'd0};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (ph_r == 2'd3);
      if (start) begin
        busy_r <= 1'b1;
        ph_r   <= '0;
      end else if (busy_r) begin
        ph_r <= ph_r + 1'b1;
        if (ph_r == 2'd3) busy_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign prod = res_r;

endmodule

### rtl/baro_comp_div.sv
// ----------------------------------------------------------------------------
// Signed 64-bit divider
// Restoring division on magnitudes, one quotient bit per cycle, with the
// quotient truncated toward zero. The divisor must be nonzero.
// ----------------------------------------------------------------------------
module baro_comp_div import baro_comp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quot
);

  logic [63:0] ad_r, rem_r, q_r, res_r;
  logic        neg_r, busy_r, done_r;
  logic [6:0]  cnt_r;
  logic [64:0] trial;
  logic        fits;

  assign trial = {rem_r, q_r[63]};
  assign fits  = (trial >= {1'b0, ad_r});

  // Datapath: one shift-subtract step per cycle, sign fix at the end.
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[63] ^ den[63];
      q_r   <= num[63] ? 64'd0 - num : num;
      ad_r  <= den[63] ? 64'd0 - den : den;
      rem_r <= '0;
    end else if (busy_r && !cnt_r[6]) begin
      rem_r <= fits ? 64'(trial - {1'b0, ad_r}) : trial[63:0];
      q_r   <= {q_r[62:0], fits};
    end else if (busy_r) begin
      res_r <= neg_r ? 64'd0 - q_r : q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && cnt_r[6];
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r[6]) busy_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign quot = res_r;

endmodule

### rtl/baro_comp_back.sv
// ----------------------------------------------------------------------------
// Back end
// Sequences the compensation formulas over the shared multiplier and the
// divider, and holds the finished result in the output register.
// ----------------------------------------------------------------------------
module baro_comp_back import baro_comp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  bc_coef_t     coef,
  input  logic         q_valid,
  input  bc_item_t     q_head,
  output logic         pop,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,
  output logic         out_tuser
);

  bc_state_t   state_r, state_nxt;
  bc_step_t    step_r, step_nxt;

  logic [RAW_W-1:0] adc_t_r, adc_p_r;
  logic [31:0] v1_r, s_r, tf_r, tf_nxt;
  logic [63:0] w1_r, ww_r, w2_r, x_r, dv_r, dv_nxt, p_r, r_r, e1_r, e2_r, sum_r;
  logic [31:0] pres_r;
  logic        pvalid_r;

  logic        mul_start, mul_done, div_start, div_done;
  logic [63:0] mul_a, mul_b, mul_p, div_q, qq, pf, tf64, centi;
  logic [31:0] t1, t2, t3;

  logic        ovalid_r;
  logic [26:0] o_centi_r;
  logic [31:0] o_fine_r, o_pres_r;
  logic        o_pv_r;
  logic        out_free;

  assign t1     = {16'd0, coef.tcoef[15:0]};
  assign t2     = 32'(sext16(coef.tcoef[31:16]));
  assign t3     = 32'(sext16(coef.tcoef[47:32]));
  assign qq     = sra64(p_r, 13);
  assign tf_nxt = v1_r + sra32(mul_p[31:0], 14);
  assign dv_nxt = sra64(mul_p, 33);
  assign tf64   = {{32{tf_r[31]}}, tf_r};
  assign centi  = sra64((tf64 << 2) + tf64 + 64'd128, 8);
  assign pf     = sra64(sum_r, 8) + (sext16(coef.pcob[47:32]) << 4);
  assign out_free = !ovalid_r || out_tready;

  baro_comp_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .op_a(mul_a), .op_b(mul_b),
    .done(mul_done), .prod(mul_p)
  );

  baro_comp_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(mul_p), .den(dv_r),
    .done(div_done), .quot(div_q)
  );

  // Operand select for each multiplication step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_r)
      MS_A_T2: begin
        mul_a = {32'd0, 32'({12'd0, adc_t_r} >> 3) - (t1 << 1)};
        mul_b = {32'd0, t2};
      end
      MS_B_B: begin
        mul_a = {32'd0, 32'({12'd0, adc_t_r} >> 4) - t1};
        mul_b = mul_a;
      end
      MS_S_T3:  begin mul_a = {32'd0, s_r}; mul_b = {32'd0, t3}; end
      MS_W_W:   begin mul_a = w1_r; mul_b = w1_r; end
      MS_WW_P6: begin mul_a = ww_r; mul_b = sext16(coef.pcob[31:16]); end
      MS_W_P5:  begin mul_a = w1_r; mul_b = sext16(coef.pcob[15:0]); end
      MS_WW_P3: begin mul_a = ww_r; mul_b = sext16(coef.pcoa[47:32]); end
      MS_W_P2:  begin mul_a = w1_r; mul_b = sext16(coef.pcoa[31:16]); end
      MS_X_P1:  begin mul_a = x_r;  mul_b = {48'd0, coef.pcoa[15:0]}; end
      MS_N_K: begin
        mul_a = ((P_BASE - 64'(adc_p_r)) << 31) - w2_r;
        mul_b = P_SCALE;
      end
      MS_P9_Q:  begin mul_a = sext16(coef.p9); mul_b = qq; end
      MS_R_Q:   begin mul_a = r_r; mul_b = qq; end
      MS_P8_P:  begin mul_a = sext16(coef.pcob[63:48]); mul_b = p_r; end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Sequencer: next state and control strobes.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    pop       = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          pop       = 1'b1;
          step_nxt  = MS_A_T2;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        mul_start = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (mul_done) begin
          state_nxt = ST_ISSUE;
          case (step_r)
            MS_A_T2:  step_nxt = MS_B_B;
            MS_B_B:   step_nxt = MS_S_T3;
            MS_S_T3:  step_nxt = MS_W_W;
            MS_W_W:   step_nxt = MS_WW_P6;
            MS_WW_P6: step_nxt = MS_W_P5;
            MS_W_P5:  step_nxt = MS_WW_P3;
            MS_WW_P3: step_nxt = MS_W_P2;
            MS_W_P2:  step_nxt = MS_X_P1;
            MS_X_P1: begin
              step_nxt = MS_N_K;
              if (dv_nxt == '0) state_nxt = ST_DONE;
            end
            MS_N_K: begin
              div_start = 1'b1;
              state_nxt = ST_DIV_WAIT;
            end
            MS_P9_Q:  step_nxt = MS_R_Q;
            MS_R_Q:   step_nxt = MS_P8_P;
            default:  state_nxt = ST_SUM;
          endcase
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          step_nxt  = MS_P9_Q;
          state_nxt = ST_ISSUE;
        end
      end
      ST_SUM:  state_nxt = ST_PACK;
      ST_PACK: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= MS_A_T2;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Working registers, loaded on pop and updated from products, quotient and sum.
  always_ff @(posedge clk) begin
    if (pop) begin
      adc_t_r <= q_head.raw_t;
      adc_p_r <= q_head.raw_p;
    end
    if (state_r == ST_WAIT && mul_done) begin
      case (step_r)
        MS_A_T2:  v1_r <= sra32(mul_p[31:0], 11);
        MS_B_B:   s_r  <= sra32(mul_p[31:0], 12);
        MS_S_T3: begin
          tf_r <= tf_nxt;
          w1_r <= {{32{tf_nxt[31]}}, tf_nxt} - T_OFFSET;
        end
        MS_W_W:   ww_r <= mul_p;
        MS_WW_P6: w2_r <= mul_p;
        MS_W_P5:  w2_r <= w2_r + (mul_p << 17) + (sext16(coef.pcoa[63:48]) << 35);
        MS_WW_P3: x_r  <= sra64(mul_p, 8);
        MS_W_P2:  x_r  <= x_r + (mul_p << 12) + P_ONE47;
        MS_X_P1: begin
          dv_r <= dv_nxt;
          if (dv_nxt == '0) begin
            pres_r   <= '0;
            pvalid_r <= 1'b0;
          end
        end
        MS_P9_Q:  r_r  <= mul_p;
        MS_R_Q:   e1_r <= sra64(mul_p, 25);
        MS_P8_P:  e2_r <= sra64(mul_p, 19);
        default:  ;
      endcase
    end
    if (state_r == ST_DIV_WAIT && div_done) p_r <= div_q;
    if (state_r == ST_SUM) sum_r <= p_r + e1_r + e2_r;
    if (state_r == ST_PACK) begin
      pvalid_r <= 1'b1;
      if (pf[63])              pres_r <= '0;
      else if (|pf[63:32])     pres_r <= '1;
      else                     pres_r <= pf[31:0];
    end
  end

  // Output register: the next item proceeds while a result waits.
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      o_centi_r <= centi[26:0];
      o_fine_r  <= tf_r;
      o_pres_r  <= pres_r;
      o_pv_r    <= pvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {5'd0, o_pres_r, o_fine_r, o_centi_r};
  assign out_tuser  = o_pv_r;

  // Only one unit finishes at a time, and only where the sequencer waits; an invalid pressure is zero.
  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == ST_WAIT) else $error("product arrived unexpectedly");
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV_WAIT) else $error("quotient arrived unexpectedly");
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !o_pv_r) |-> o_pres_r == '0) else $error("invalid pressure not zero");

endmodule

### rtl/barometric_compensation_top.sv
// ----------------------------------------------------------------------------
// Barometric compensation top level
// Configuration registers, front end queue and back end compensation engine.
// ----------------------------------------------------------------------------
// Each input beat carries one raw temperature and one raw pressure sample and
// yields one result beat. The back end takes the item, forms 13 wrapping
// 64-bit products on one shared 32x32 multiplier and one quotient in the
// signed divider, then sums, saturates and hands the result to the output
// register. An item whose pressure divisor is zero skips the divider, the
// last four products, the sum and the saturation. A four-deep queue accepts
// new beats while an item is worked on, and the output register lets the
// next item run while a result waits. Calibration is to be written by the
// user over the configuration port only while the block is idle; the block
// itself does not enforce this.
module barometric_compensation_top import baro_comp_pkg::*; #(
  parameter int RAW_BITS = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [39:0]       in_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [95:0]       out_tdata,  // temperature_centi[26:0], fine_temperature[58:27],
                                        // pressure_q24_8[90:59], zero[95:91]
  output logic              out_tuser,  // pressure_valid
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [63:0]       cfg_pwdata,
  output logic [63:0]       cfg_prdata,
  output logic              cfg_pready
);

  bc_coef_t coef_r;
  logic     pop, q_valid, wr_en;
  bc_item_t q_head;
  logic [1:0] idx;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[4:3];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Calibration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_TCOEF: coef_r.tcoef <= cfg_pwdata[47:0];
        REG_PCOA:  coef_r.pcoa  <= cfg_pwdata;
        REG_PCOB:  coef_r.pcob  <= cfg_pwdata;
        REG_P9:    coef_r.p9    <= cfg_pwdata[15:0];
        default:   ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (idx)
      REG_TCOEF: cfg_prdata = {16'd0, coef_r.tcoef};
      REG_PCOA:  cfg_prdata = coef_r.pcoa;
      REG_PCOB:  cfg_prdata = coef_r.pcob;
      REG_P9:    cfg_prdata = {48'd0, coef_r.p9};
      default:   cfg_prdata = '0;
    endcase
  end

  baro_comp_front #(.RAW_BITS(RAW_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .pop(pop), .q_valid(q_valid), .q_head(q_head)
  );

  baro_comp_back u_back (
    .clk(clk), .rst_n(rst_n), .coef(coef_r), .q_valid(q_valid), .q_head(q_head),
    .pop(pop), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

endmodule
